### design/gpib_ah_pkg.sv
// Package for the GPIB acceptor handshake: payload and config structs,
// handshake phase codes, register indexes and protocol constants.
// No dependencies.
`default_nettype none

package gpib_ah_pkg;

    localparam int CMD_BUF_LEN_DEF = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BINARY_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EOT_ENABLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_EOT_CHAR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DAV_TIMEOUT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EOI_TIMEOUT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES   = 3'd5;

    // Handshake phases
    localparam logic [3:0] PH_IDLE          = 4'd0;
    localparam logic [3:0] PH_START         = 4'd1;
    localparam logic [3:0] PH_ACCEPT        = 4'd2;
    localparam logic [3:0] PH_WAIT_DAV      = 4'd3;
    localparam logic [3:0] PH_DAV_LOW       = 4'd4;
    localparam logic [3:0] PH_WAIT_DAV_HIGH = 4'd5;
    localparam logic [3:0] PH_DAV_HIGH      = 4'd6;
    localparam logic [3:0] PH_EOI           = 4'd7;
    localparam logic [3:0] PH_DAV_TIMEOUT   = 4'd8;
    localparam logic [3:0] PH_FINISH        = 4'd9;

    localparam logic [7:0] CHAR_LF       = 8'h0a;
    localparam logic [7:0] CMD_LISTEN    = 8'h20;
    localparam logic [7:0] CMD_UNLISTEN  = 8'h3f;
    localparam logic [7:0] EOT_CHAR_RST  = 8'h0a;
    localparam logic [15:0] DAV_TMO_RST  = 16'd2000;
    localparam logic [15:0] EOI_TMO_RST  = 16'd1000;
    localparam logic [7:0] MAX_BYTES_RST = 8'd254;

    typedef struct packed {
        logic       start_req;
        logic       dav_n;
        logic       eoi_n;
        logic       atn_n;
        logic [7:0] dio_n;
    } t_in;

    typedef struct packed {
        logic       nrfd_low;
        logic       ndac_low;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic       byte_is_command;
        logic       listen_active;
        logic       done_res;
        logic       timed_out;
        logic [7:0] byte_count;
    } t_out;

    typedef struct packed {
        logic        binary_mode;
        logic        eot_enable;
        logic [7:0]  eot_char;
        logic [15:0] dav_timeout;
        logic [15:0] eoi_timeout;
        logic [7:0]  max_bytes;
    } t_cfg;

    typedef struct packed {
        logic [3:0]  phase;
        logic [15:0] dav_wait_left;
        logic [15:0] eoi_wait_left;
        logic [7:0]  received_count;
        logic [7:0]  last_byte;
        logic        eoi_latched;
        logic        listening_flag;
        logic        command_mode;
        logic        drive_nrfd;
        logic        drive_ndac;
    } t_state;

    localparam t_state STATE_RST = '{
        phase:          PH_IDLE,
        dav_wait_left:  16'd0,
        eoi_wait_left:  16'd0,
        received_count: 8'd0,
        last_byte:      8'd0,
        eoi_latched:    1'b1,
        listening_flag: 1'b0,
        command_mode:   1'b0,
        drive_nrfd:     1'b0,
        drive_ndac:     1'b0
    };

endpackage

`default_nettype wire

### design/gpib_acceptor_handshake.sv
// Top level of the GPIB acceptor handshake: input register, handshake state,
// result register. Depends on gpib_ah_pkg, gpib_ah_cfg and gpib_ah_core.
//
//   channel  direction  handshake                 payload
//   in       to block   i_in_valid / o_in_ready   i_in_data   (t_in)
//   out      from block o_out_valid / i_out_ready o_out_data  (t_out)
//   cfg      to block   i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One result per bus sample; a sample is taken every cycle while the result
// side keeps up. A sample passes the input register, then the state update
// and result register in one pass. A stalled result holds the pipe; the input
// register refills in the cycle the result is taken. Reset is synchronous,
// active low, and returns the handshake to idle with both lines released.
`default_nettype none

module gpib_acceptor_handshake
    import gpib_ah_pkg::*;
#(
    parameter int CMD_BUF_LEN = CMD_BUF_LEN_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in                   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out                       o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CW = $clog2(CMD_BUF_LEN);

    t_cfg          cfg;
    t_in           r_in;
    logic          r_in_vld;
    t_state        r_st;
    t_state        n_st;
    logic [CW-1:0] r_cmd_cnt;
    logic [CW-1:0] n_cmd_cnt;
    t_out          r_out;
    t_out          n_out;
    logic          r_out_vld;
    logic          advance;

    assign o_cfg_ready = 1'b1;

    gpib_ah_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    gpib_ah_core #(
        .CMD_BUF_LEN (CMD_BUF_LEN)
    ) u_core (
        .i_item    (r_in),
        .i_cfg     (cfg),
        .i_st      (r_st),
        .i_cmd_cnt (r_cmd_cnt),
        .o_st      (n_st),
        .o_cmd_cnt (n_cmd_cnt),
        .o_res     (n_out)
    );

    // advance the sample when the result slot is free or being emptied
    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_st      <= STATE_RST;
            r_cmd_cnt <= '0;
        end else begin
            if (o_in_ready) r_in_vld <= i_in_valid;
            if (advance) begin
                r_st      <= n_st;
                r_cmd_cnt <= n_cmd_cnt;
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) r_in  <= i_in_data;
        if (advance)                  r_out <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    a_tmo_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.timed_out |-> o_out_data.done_res)
        else $error("timeout flagged without done");

    a_cmd_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.byte_is_command |-> o_out_data.byte_valid)
        else $error("command flag without a byte");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && n_out.done_res |=> r_st.phase == PH_IDLE)
        else $error("receive finished but handshake not idle");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !advance |=> r_in_vld && $stable(r_in))
        else $error("held sample lost");

endmodule

`default_nettype wire

### design/gpib_ah_cfg.sv
// Configuration register file for the GPIB acceptor handshake.
// Depends on gpib_ah_pkg.
`default_nettype none

module gpib_ah_cfg
    import gpib_ah_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_we,
    input  wire logic [CFG_IDX_W-1:0]  i_index,
    input  wire logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.binary_mode <= 1'b0;
            r_cfg.eot_enable  <= 1'b0;
            r_cfg.eot_char    <= EOT_CHAR_RST;
            r_cfg.dav_timeout <= DAV_TMO_RST;
            r_cfg.eoi_timeout <= EOI_TMO_RST;
            r_cfg.max_bytes   <= MAX_BYTES_RST;
        end else if (i_we) begin
            case (i_index)
                REG_BINARY_MODE: r_cfg.binary_mode <= i_data[0];
                REG_EOT_ENABLE:  r_cfg.eot_enable  <= i_data[0];
                REG_EOT_CHAR:    r_cfg.eot_char    <= i_data[7:0];
                REG_DAV_TIMEOUT: r_cfg.dav_timeout <= i_data;
                REG_EOI_TIMEOUT: r_cfg.eoi_timeout <= i_data;
                REG_MAX_BYTES:   r_cfg.max_bytes   <= i_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### design/gpib_ah_core.sv
// Next-state and result logic of the acceptor handshake for one bus sample.
// Depends on gpib_ah_pkg.
`default_nettype none

module gpib_ah_core
    import gpib_ah_pkg::*;
#(
    parameter int CMD_BUF_LEN = CMD_BUF_LEN_DEF,
    localparam int CW = $clog2(CMD_BUF_LEN)
) (
    input  wire t_in         i_item,
    input  wire t_cfg        i_cfg,
    input  wire t_state      i_st,
    input  wire logic [CW-1:0] i_cmd_cnt,
    output t_state           o_st,
    output logic [CW-1:0]    o_cmd_cnt,
    output t_out             o_res
);

    localparam logic [CW-1:0] CMD_MAX = CW'(CMD_BUF_LEN - 1);

    t_state     s;
    logic [CW-1:0] cnt;
    logic [7:0] b;
    logic       bv;
    logic [7:0] bval;
    logic       bcmd;
    logic       done;
    logic       tmo;

    always_comb begin
        s    = i_st;
        cnt  = i_cmd_cnt;
        b    = ~i_item.dio_n;
        bv   = 1'b0;
        bval = 8'd0;
        bcmd = 1'b0;
        done = 1'b0;
        tmo  = 1'b0;

        if (s.phase == PH_IDLE && i_item.start_req) begin
            s.phase          = PH_START;
            s.received_count = 8'd0;
            s.last_byte      = 8'd0;
        end

        if (s.phase != PH_IDLE) begin
            // end checks override the current phase
            if (s.received_count >= i_cfg.max_bytes) s.phase = PH_FINISH;
            if (s.received_count != 8'd0 && s.last_byte == CHAR_LF && !i_cfg.binary_mode)
                s.phase = PH_FINISH;

            case (s.phase)
                PH_START: begin
                    s.drive_nrfd = 1'b1;
                    s.drive_ndac = 1'b1;
                    s.phase      = PH_ACCEPT;
                end
                PH_ACCEPT: begin
                    s.drive_nrfd    = 1'b0;
                    s.dav_wait_left = i_cfg.dav_timeout;
                    s.phase         = PH_WAIT_DAV;
                end
                PH_WAIT_DAV: begin
                    if (!i_item.dav_n) s.phase = PH_DAV_LOW;
                    s.dav_wait_left = s.dav_wait_left - 16'd1;
                    if (s.dav_wait_left == 16'd0) s.phase = PH_DAV_TIMEOUT;
                end
                PH_DAV_LOW: begin
                    s.drive_nrfd  = 1'b1;
                    s.eoi_latched = i_item.eoi_n;
                    if (!i_item.atn_n) begin
                        s.command_mode = 1'b1;
                        if (b == CMD_LISTEN)   s.listening_flag = 1'b1;
                        if (b == CMD_UNLISTEN) s.listening_flag = 1'b0;
                    end
                    if (s.command_mode && cnt < CMD_MAX) cnt = cnt + CW'(1);
                    s.last_byte      = b;
                    s.received_count = s.received_count + 8'd1;
                    bv               = 1'b1;
                    bval             = b;
                    bcmd             = s.command_mode;
                    s.drive_ndac     = 1'b0;
                    s.phase          = PH_WAIT_DAV_HIGH;
                end
                PH_WAIT_DAV_HIGH: begin
                    if (i_item.dav_n) s.phase = PH_DAV_HIGH;
                end
                PH_DAV_HIGH: begin
                    s.drive_ndac = 1'b1;
                    if (!s.eoi_latched) begin
                        s.phase         = PH_EOI;
                        s.eoi_wait_left = i_cfg.eoi_timeout;
                        // append the end character if enabled and the byte limit is not yet reached
                        if (i_cfg.eot_enable && s.received_count < i_cfg.max_bytes) begin
                            s.last_byte      = i_cfg.eot_char;
                            s.received_count = s.received_count + 8'd1;
                            bv               = 1'b1;
                            bval             = i_cfg.eot_char;
                        end
                    end else begin
                        s.phase = PH_ACCEPT;
                    end
                end
                PH_EOI: begin
                    s.drive_ndac = 1'b0;
                    if (i_item.eoi_n) s.phase = PH_FINISH;
                    s.eoi_wait_left = s.eoi_wait_left - 16'd1;
                    if (s.eoi_wait_left == 16'd0) s.phase = PH_FINISH;
                    s.command_mode = 1'b0;
                end
                PH_DAV_TIMEOUT: begin
                    tmo            = 1'b1;
                    s.command_mode = 1'b0;
                    s.drive_nrfd   = 1'b1;
                    s.drive_ndac   = 1'b1;
                    done           = 1'b1;
                    s.phase        = PH_IDLE;
                end
                PH_FINISH: begin
                    s.drive_nrfd = 1'b1;
                    s.drive_ndac = 1'b1;
                    done         = 1'b1;
                    s.phase      = PH_IDLE;
                end
                default: begin
                    s.phase = PH_IDLE;
                end
            endcase
        end
    end

    assign o_st      = s;
    assign o_cmd_cnt = cnt;

    assign o_res.nrfd_low        = s.drive_nrfd;
    assign o_res.ndac_low        = s.drive_ndac;
    assign o_res.byte_valid      = bv;
    assign o_res.byte_value      = bval;
    assign o_res.byte_is_command = bcmd;
    assign o_res.listen_active   = s.listening_flag;
    assign o_res.done_res        = done;
    assign o_res.timed_out       = tmo;
    assign o_res.byte_count      = s.received_count;

endmodule

`default_nettype wire
